### design/tea_dec_pkg.sv
// ----------------------------------------------------------------------------
// TEA-style block decryptor package
// Beat types and cipher constants shared by the round cells and the top level.
// ----------------------------------------------------------------------------
package tea_dec_pkg;

    localparam int unsigned WORD_W = 32;

    // round sum at the first round, and its per-round increment
    localparam logic [WORD_W-1:0] SUM_START = 32'hC6EF3720;
    localparam logic [WORD_W-1:0] SUM_STEP  = 32'h61C88647;

    // key register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_IDX3 = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_left;
        logic [WORD_W-1:0] cipher_right;
    } t_cipher;

    typedef struct packed {
        logic [WORD_W-1:0] plain_left;
        logic [WORD_W-1:0] plain_right;
    } t_plain;

    // block halves as they travel down the cell chain
    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } t_halves;

    // arithmetic shift right by five
    function automatic logic [WORD_W-1:0] sar5(input logic [WORD_W-1:0] x);
        return {{5{x[WORD_W-1]}}, x[WORD_W-1:5]};
    endfunction

endpackage

### design/tea_dec_cell.sv
// ----------------------------------------------------------------------------
// TEA decrypt half-round cell
// One registered stage: subtracts the mix of one half from the other half.
// ----------------------------------------------------------------------------
module tea_dec_cell #(
    parameter bit          UPDATE_LEFT = 1'b0,
    parameter logic [31:0] ROUND_SUM   = 32'h0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tea_dec_pkg::t_halves  i_data,
    input  logic [31:0]           i_key_shl,
    input  logic [31:0]           i_key_sar,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tea_dec_pkg::t_halves  o_data
);

    logic                 r_valid;
    tea_dec_pkg::t_halves r_data;
    tea_dec_pkg::t_halves n_data;
    logic                 w_ready;
    logic [31:0]          w_src;
    logic [31:0]          w_mix;

    // stage can take a beat when empty or when its beat leaves this cycle
    assign w_ready = !r_valid || !i_stall;
    assign o_stall = !w_ready;

    assign w_src = UPDATE_LEFT ? i_data.right : i_data.left;
    assign w_mix = (tea_dec_pkg::sar5(w_src) + i_key_sar)
                 ^ ({w_src[27:0], 4'b0000} + i_key_shl)
                 ^ (ROUND_SUM + w_src);

    always_comb begin
        n_data = i_data;
        if (UPDATE_LEFT) begin
            n_data.left = i_data.left - w_mix;
        end else begin
            n_data.right = i_data.right - w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### design/tea_block_decrypt.sv
// Decrypts one 64-bit block per cycle while the output is not stalled, with a
// TEA-style cipher (arithmetic shift right by five, round sum starting at
// 0xC6EF3720 and stepping by 0x61C88647). Each round is split into two
// half-round cells, so the chain is 2*ROUNDS registered cells deep, and
// throughput is one block per cycle while unstalled, set by the
// one-stage-per-cell chain. The last cell's register is the output
// register. Each cell holds its beat on downstream stall while upstream empty
// cells keep filling, so input beats are still taken while a finished block
// waits, until every cell is full. The four key words are written through the
// configuration port and must only change while no block is in flight.
// ----------------------------------------------------------------------------
// TEA-style block decryptor, top level
// Key registers plus a chain of half-round cells.
// ----------------------------------------------------------------------------
module tea_block_decrypt #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // ciphertext beats
    input  logic                                i_valid,
    output logic                                o_stall,
    input  tea_dec_pkg::t_cipher                i_data,
    // plaintext beats
    output logic                                o_valid,
    input  logic                                i_stall,
    output tea_dec_pkg::t_plain                 o_data,
    // key write port
    input  logic                                i_cfg_wr_en,
    input  logic [tea_dec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tea_dec_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int unsigned CELLS = 2 * ROUNDS;

    logic [31:0] r_key0;
    logic [31:0] r_key1;
    logic [31:0] r_key2;
    logic [31:0] r_key3;

    // link k feeds cell k; link CELLS is the output
    logic                 w_valid [CELLS+1];
    logic                 w_stall [CELLS+1];
    tea_dec_pkg::t_halves w_data  [CELLS+1];
    logic [CELLS-1:0]     w_full;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tea_dec_pkg::KEY_IDX0: r_key0 <= i_cfg_data;
                tea_dec_pkg::KEY_IDX1: r_key1 <= i_cfg_data;
                tea_dec_pkg::KEY_IDX2: r_key2 <= i_cfg_data;
                tea_dec_pkg::KEY_IDX3: r_key3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_valid[0]      = i_valid;
    assign w_data[0].left  = i_data.cipher_left;
    assign w_data[0].right = i_data.cipher_right;
    assign o_stall         = w_stall[0];

    // even cell: right -= mix(left, k2, k3); odd cell: left -= mix(right, k0, k1)
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        localparam logic [31:0] CELL_SUM = tea_dec_pkg::SUM_START
                                         + (32'(c / 2) * tea_dec_pkg::SUM_STEP);
        localparam bit          ODD      = (c % 2) == 1;

        tea_dec_cell #(
            .UPDATE_LEFT (ODD),
            .ROUND_SUM   (CELL_SUM)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[c]),
            .o_stall   (w_stall[c]),
            .i_data    (w_data[c]),
            .i_key_shl (ODD ? r_key0 : r_key2),
            .i_key_sar (ODD ? r_key1 : r_key3),
            .o_valid   (w_valid[c+1]),
            .i_stall   (w_stall[c+1]),
            .o_data    (w_data[c+1])
        );

        assign w_full[c] = w_valid[c+1];
    end

    assign w_stall[CELLS]    = i_stall;
    assign o_valid           = w_valid[CELLS];
    assign o_data.plain_left  = w_data[CELLS].left;
    assign o_data.plain_right = w_data[CELLS].right;

    // input is held off only when every cell holds a beat
    a_stall_only_when_full: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_stall |-> (&w_full))
        else $error("input stalled with an empty cell in the chain");

    // reset empties the whole chain
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_full == '0))
        else $error("cell chain not empty after reset");

    // the output beat only leaves when it was taken
    a_out_leaves_on_take: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (o_valid && i_stall) |=> o_valid)
        else $error("output beat dropped while stalled");

    // a beat entering the first cell occupies it next cycle
    a_first_cell_loads: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (i_valid && !o_stall) |=> w_full[0])
        else $error("accepted beat missing from first cell");

endmodule
